// ===== sv/chfe_pkg.sv =====
// Package for the hex text frame encoder with CRC-32.
// Holds the queue entry type, character constants and the CRC and hex helpers.
// No dependencies.
`default_nettype none

package chfe_pkg;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [7:0]  OPEN_CHAR    = 8'h3C;
    localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;

    // One accepted byte as the back end needs it.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        opens;     // first byte of a frame, needs the '<' prefix
        logic        last;      // closes the frame, CRC digits and newline follow
        logic [31:0] crc;       // CRC including this byte
    } t_entry;

    // Reflected CRC-32 update by one byte, bit by bit.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'h00_0000, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Upper-case ASCII hex digit.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'h0, nib};
        end else begin
            r = 8'h37 + {4'h0, nib};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/chfe_channels_if.sv =====
// Valid/ready channel interfaces of the hex text frame encoder.
// chfe_in_if carries payload bytes, chfe_out_if carries output characters.
// No dependencies.
`default_nettype none

interface chfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface chfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       end_of_frame;

    modport source (output valid, output out_char, output end_of_frame, input ready);
    modport sink   (input valid, input out_char, input end_of_frame, output ready);
endinterface

`default_nettype wire

// ===== sv/chfe_front.sv =====
// Front end: accepts payload bytes, tracks frame state and runs the CRC.
// Uses chfe_pkg and chfe_in_if; pushes one t_entry per byte into the queue.
`default_nettype none

module chfe_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    chfe_in_if.sink            i_in,
    input  wire logic          i_q_full,
    output logic               o_push,
    output chfe_pkg::t_entry   o_entry
);
    import chfe_pkg::*;

    logic        r_frame_open;
    logic        n_frame_open;
    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] crc_base;
    logic [31:0] crc_new;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        // A new frame starts its CRC from zero.
        crc_base = r_frame_open ? r_crc : 32'h0000_0000;
        crc_new  = crc_byte(crc_base, i_in.data_byte);

        o_entry.data_byte = i_in.data_byte;
        o_entry.opens     = !r_frame_open;
        o_entry.last      = i_in.last_byte;
        o_entry.crc       = crc_new;

        n_frame_open = r_frame_open;
        n_crc        = r_crc;
        if (o_push) begin
            if (i_in.last_byte) begin
                n_frame_open = 1'b0;
                n_crc        = 32'h0000_0000;
            end else begin
                n_frame_open = 1'b1;
                n_crc        = crc_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_crc        <= 32'h0000_0000;
        end else begin
            r_frame_open <= n_frame_open;
            r_crc        <= n_crc;
        end
    end

    // A byte marked last closes the frame, so the next byte opens a new one.
    a_close_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_in.last_byte) |=> !r_frame_open)
        else $error("frame still open after its last byte");

endmodule

`default_nettype wire

// ===== sv/chfe_queue.sv =====
// Two-entry queue between the front end and the character serializer.
// Uses chfe_pkg for the entry type.
`default_nettype none

module chfe_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  chfe_pkg::t_entry   i_entry,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_pop,
    output chfe_pkg::t_entry   o_entry
);
    import chfe_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            unique if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end else begin
                r_count <= r_count;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |-> i_pop)
        else $error("push into a full queue");

endmodule

`default_nettype wire

// ===== sv/chfe_back.sv =====
// Back end: turns queue entries into ASCII characters, one per cycle while the receiver is ready,
// through a registered output stage. Uses chfe_pkg and chfe_out_if.
`default_nettype none

module chfe_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  chfe_pkg::t_entry   i_q_entry,
    output logic               o_pop,
    chfe_out_if.source         o_out
);
    import chfe_pkg::*;

    // Character position within one entry.
    localparam logic [3:0] PH_OPEN = 4'd0;
    localparam logic [3:0] PH_HI   = 4'd1;
    localparam logic [3:0] PH_LO   = 4'd2;
    localparam logic [3:0] PH_CRC0 = 4'd3;
    localparam logic [3:0] PH_NL   = 4'd11;

    t_entry     r_cur;
    t_entry     n_cur;
    logic       r_busy;
    logic       n_busy;
    logic [3:0] r_phase;
    logic [3:0] n_phase;
    logic       r_out_valid;
    logic       n_out_valid;
    logic [7:0] r_char;
    logic [7:0] n_char;
    logic       r_eof;
    logic       n_eof;

    logic       can_load;
    logic       step;
    logic       entry_done;
    logic [7:0] cur_char;
    logic [3:0] crc_idx;
    logic [4:0] crc_shift;
    logic [31:0] crc_shifted;

    assign o_out.valid        = r_out_valid;
    assign o_out.out_char     = r_char;
    assign o_out.end_of_frame = r_eof;

    always_comb begin
        // CRC digits go least significant byte first, high nibble first.
        crc_idx     = r_phase - PH_CRC0;
        crc_shift   = {crc_idx[2:1], ~crc_idx[0], 2'b00};
        crc_shifted = r_cur.crc >> crc_shift;

        unique case (r_phase)
            PH_OPEN: cur_char = OPEN_CHAR;
            PH_HI:   cur_char = hex_digit(r_cur.data_byte[7:4]);
            PH_LO:   cur_char = hex_digit(r_cur.data_byte[3:0]);
            PH_NL:   cur_char = NEWLINE_CHAR;
            default: cur_char = hex_digit(crc_shifted[3:0]);
        endcase

        can_load   = !r_out_valid || o_out.ready;
        step       = r_busy && can_load;
        entry_done = (r_phase == PH_LO && !r_cur.last) || (r_phase == PH_NL);
        o_pop      = i_q_valid && (!r_busy || (step && entry_done));

        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_eof       = r_eof;
        if (step) begin
            n_out_valid = 1'b1;
            n_char      = cur_char;
            n_eof       = (r_phase == PH_NL);
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        n_cur   = r_cur;
        n_busy  = r_busy;
        n_phase = r_phase;
        priority if (o_pop) begin
            n_cur   = i_q_entry;
            n_busy  = 1'b1;
            n_phase = i_q_entry.opens ? PH_OPEN : PH_HI;
        end else if (step && entry_done) begin
            n_busy = 1'b0;
        end else if (step) begin
            n_phase = r_phase + 4'd1;
        end else begin
            n_phase = r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_char <= n_char;
        r_eof  <= n_eof;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_OPEN;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    a_eof_on_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_eof) |-> (r_char == NEWLINE_CHAR))
        else $error("end of frame flagged on a character other than newline");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_phase <= PH_NL))
        else $error("serializer phase out of range");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

// ===== sv/crc32_hex_ascii_frame_encoder.sv =====
// Hex text frame encoder with CRC-32 (reflected, poly 0xEDB88320, init 0).
// Each payload byte on i_in becomes two upper-case hex characters on o_out.
// The first byte of a frame is preceded by '<'. The byte with last_byte set
// is followed by the frame CRC as eight hex digits, least significant byte
// first, and a newline with end_of_frame set; the next byte opens a new frame.
// Both channels are valid/ready; a transfer happens when both are high.
// When the serializer is idle, the first character of a byte passes through
// the queue, the serializer's entry register and the output register.
// Throughput: one character per cycle while entries wait and the receiver is
// ready; a byte gives two characters, an opening byte adds '<' and a closing
// byte adds the eight CRC digits and the newline. A two-entry queue decouples
// input from the serializer, so bytes are taken while a character waits in the
// output register. When the receiver stalls, the output holds its character,
// the queue fills and i_in.ready drops. Synchronous reset clears the queue,
// the CRC and the frame state; no frame is open after reset.
// Depends on chfe_pkg, chfe_channels_if, chfe_front, chfe_queue, chfe_back.
`default_nettype none

module crc32_hex_ascii_frame_encoder (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    chfe_in_if.sink   i_in,
    chfe_out_if.source o_out
);
    import chfe_pkg::*;

    logic   push;
    logic   q_full;
    logic   q_valid;
    logic   pop;
    t_entry push_entry;
    t_entry head_entry;

    chfe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    chfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_entry (head_entry)
    );

    chfe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (head_entry),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

// ===== tb/crc32_hex_ascii_frame_encoder_test.sv =====
// Testbench for crc32_hex_ascii_frame_encoder: payload frames go in, hex text comes out.
// A clocked driver, receiver and monitor check every character against an in-bench model.
// Depends on chfe_pkg, chfe_channels_if and the encoder RTL.
module crc32_hex_ascii_frame_encoder_test;

    localparam int          CLK_PERIOD    = 20;
    localparam int          RESET_CYCLES  = 8;
    localparam int          RANDOM_BYTES  = 80;
    localparam int          CALM_BYTES    = 25;
    localparam int          HOLD_AT       = 40;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          DRAIN_CYCLES  = 30;
    localparam int          LIMIT_CYCLES  = 200_000;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [31:0] FRAME_POLY    = 32'hEDB8_8320;
    localparam logic [7:0]  CHAR_OPEN     = 8'h3C;
    localparam logic [7:0]  CHAR_NEWLINE  = 8'h0A;
    localparam logic [7:0]  CHAR_ZERO     = 8'h30;
    localparam logic [7:0]  CHAR_A        = 8'h41;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_payload;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_frame;
    } t_text_char;

    logic i_clk = 1'b0;
    logic i_rst_n;

    chfe_in_if  in_ch();
    chfe_out_if out_ch();

    crc32_hex_ascii_frame_encoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_payload    pending_bytes[$];
    t_text_char  expected_chars[$];
    t_payload    next_byte;
    t_text_char  want_char;
    logic [31:0] frame_crc     = 32'h0;
    logic        frame_started = 1'b0;
    int          total_bytes   = 0;
    int          bytes_offered = 0;
    int          bytes_accepted = 0;
    int          tx_gap_left   = 0;
    int          rx_stall_left = 0;
    int          rx_hold_left  = 0;
    logic        rx_hold_done  = 1'b0;
    int          mismatches    = 0;

    wire calm_phase = (bytes_accepted + CALM_BYTES >= total_bytes);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void add_byte(input logic [7:0] b, input logic last);
        t_payload p;
        p.data_byte = b;
        p.last_byte = last;
        pending_bytes.push_back(p);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? CHAR_ZERO + 8'(nib) : CHAR_A + 8'(nib) - 8'd10;
    endfunction

    function automatic void push_char(input logic [7:0] c, input logic eof);
        t_text_char t;
        t.out_char     = c;
        t.end_of_frame = eof;
        expected_chars.push_back(t);
    endfunction

    function automatic void push_hex(input logic [7:0] b);
        push_char(hex_char(b[7:4]), 1'b0);
        push_char(hex_char(b[3:0]), 1'b0);
    endfunction

    // Work out the characters that one accepted payload byte produces.
    function automatic void predict_text(input logic [7:0] b, input logic last);
        logic [31:0] c;
        if (!frame_started) begin
            push_char(CHAR_OPEN, 1'b0);
            frame_crc     = 32'h0;
            frame_started = 1'b1;
        end
        push_hex(b);
        c = frame_crc ^ {24'h0, b};
        repeat (8) c = (c >> 1) ^ (FRAME_POLY & {32{c[0]}});
        frame_crc = c;
        if (last) begin
            for (int k = 0; k < 4; k++) begin
                push_hex(frame_crc[8*k +: 8]);
            end
            push_char(CHAR_NEWLINE, 1'b1);
            frame_crc     = 32'h0;
            frame_started = 1'b0;
        end
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: %s", what);
        end
    endfunction

    // Driver: a new byte goes out once the previous one has been transferred.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (bytes_accepted == bytes_offered) begin
            if (tx_gap_left != 0) begin
                tx_gap_left--;
                in_ch.valid <= 1'b0;
            end else if (pending_bytes.size() == 0) begin
                in_ch.valid <= 1'b0;
            end else if (!calm_phase
                         && !(bytes_accepted >= HOLD_AT && bytes_accepted < HOLD_AT + 6)
                         && $urandom_range(0, 7) == 0) begin
                tx_gap_left = $urandom_range(0, 6);
                in_ch.valid <= 1'b0;
            end else begin
                next_byte = pending_bytes.pop_front();
                in_ch.data_byte <= next_byte.data_byte;
                in_ch.last_byte <= next_byte.last_byte;
                in_ch.valid     <= 1'b1;
                bytes_offered++;
            end
        end
    end

    // Receiver: random stalls, plus one long hold that backs the encoder up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (!rx_hold_done && bytes_accepted >= HOLD_AT) begin
                rx_hold_done = 1'b1;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_stall_left != 0) begin
                rx_stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
                rx_stall_left = $urandom_range(0, 6);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each input transfer and checks each output transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                predict_text(in_ch.data_byte, in_ch.last_byte);
                bytes_accepted++;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_chars.size() == 0) begin
                    note_mismatch($sformatf("unexpected char 0x%02h eof %0b",
                                            out_ch.out_char, out_ch.end_of_frame));
                end else begin
                    want_char = expected_chars.pop_front();
                    if (out_ch.out_char !== want_char.out_char
                        || out_ch.end_of_frame !== want_char.end_of_frame) begin
                        note_mismatch($sformatf(
                            "char expected 0x%02h eof %0b, got 0x%02h eof %0b",
                            want_char.out_char, want_char.end_of_frame,
                            out_ch.out_char, out_ch.end_of_frame));
                    end
                end
            end
        end
    end

    initial begin
        int len;
        int random_count;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.last_byte = 1'b0;
        out_ch.ready    = 1'b0;

        // Single-byte frames at both extremes, then a frame of bit patterns.
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h0F, 1'b0);
        add_byte(8'hF0, 1'b0);
        add_byte(8'h55, 1'b0);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h01, 1'b1);
        // The usual "123456789" check string.
        for (int k = 0; k < 9; k++) begin
            add_byte(8'h31 + 8'(k), k == 8);
        end
        add_byte(8'hA5, 1'b0);
        add_byte(8'h5A, 1'b1);

        // Random frames, mostly short, now and then a longer one.
        random_count = 0;
        while (random_count < RANDOM_BYTES) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                add_byte(8'($urandom_range(0, 255)), k == len - 1);
            end
            random_count += len;
        end
        total_bytes = pending_bytes.size();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (bytes_accepted != total_bytes);
        do @(negedge i_clk); while (expected_chars.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
